FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file dorq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on clk_i, disabled while reset is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that a condition never holds while out of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: rtl/dorq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dorq_pkg;

  localparam int unsigned QueueDepthDefault = 16;

  typedef enum logic [2:0] {
    ActSubmit   = 3'd0,
    ActCancel   = 3'd1,
    ActTick     = 3'd2,
    ActResult   = 3'd3,
    ActShutdown = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    EvDispatch = 3'd0,
    EvExpired  = 3'd1,
    EvDeliver  = 3'd2,
    EvAbort    = 3'd3,
    EvFlushed  = 3'd4,
    EvReject   = 3'd5,
    EvFinished = 3'd6
  } event_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] request_tag;
    logic [7:0]  block_type;
    logic [15:0] timeout_ticks;
    logic        at_head;
    logic        end_of_results;
  } req_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] tag_out;
    logic [7:0]  type_out;
    logic [15:0] remaining_ticks;
    logic        last;
  } res_t;

  // One queue entry as held in the entry memory.
  typedef struct packed {
    logic [15:0] tag;
    logic [7:0]  btype;
    logic [31:0] deadline;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage
`default_nettype wire

FILE: rtl/dorq_entry_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module dorq_entry_ram
  import dorq_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire entry_t        wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output entry_t             rdata_o
);

  entry_t mem [Depth];

  // Write one entry, read one entry with a registered output.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/deadline_ordered_request_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Earliest-deadline-first request queue with one running slot. Waiting requests
// sit in a single-write, single-read entry memory of QueueDepth entries, kept in
// queue order, and a sequencer walks that memory one entry per cycle, reading an
// entry and writing it back shifted where needed; a walk that emits events holds
// while an event waits on a stalled result channel. One request is worked at a
// time and the request channel is ready only while the sequencer is idle. A
// shutdown walks every entry and then flushes the running slot; a submit walks
// from the tail to its place; a tick, or a cancel that misses the running
// request, walks the whole queue; a finished iteration dispatches the head and
// shifts the rest down. Events for a request appear in order on the result
// channel, the final one flagged by last.
module deadline_ordered_request_queue_core
  import dorq_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  input  wire req_t req_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output res_t      res_o
);

  localparam int unsigned AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CW = $clog2(QueueDepth + 1);
  localparam logic [CW-1:0] DepthC = CW'(QueueDepth);

  typedef enum logic [6:0] {
    StIdle  = 7'b000_0001,
    StScan  = 7'b000_0010, // examine entry at ri
    StIns   = 7'b000_0100, // write new entry
    StDisp  = 7'b000_1000, // head available for dispatch
    StShift = 7'b001_0000, // shift entries down after dispatch
    StFlRun = 7'b010_0000,
    StDone  = 7'b100_0000
  } state_e;

  state_e state_q, state_d;
  req_t   req_q;
  logic [CW-1:0] count_q, count_d;
  logic        run_valid_q, run_valid_d;
  logic [15:0] run_tag_q, run_tag_d;
  logic        run_canc_q, run_canc_d;
  logic [31:0] time_q, time_d;
  // walk pointers: rd index (entry being looked at), wr index (compaction target)
  logic [CW-1:0] ri_q, ri_d, wi_q, wi_d;
  logic        found_q, found_d;
  logic        fwd_q, fwd_d;     // head is the entry just written

  res_t  out_q, out_d;
  logic  out_v_q, out_v_d;
  res_t  pend_q, pend_d;         // newest event, held until the next one is known
  logic  pend_v_q, pend_v_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  dorq_entry_ram #(.Depth(QueueDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic [31:0] new_dl, new_rel, rel_rd, head_rel;
  logic        rd_reached, new_before;
  entry_t      new_ent, head;
  logic        out_free, emit_ok;
  assign new_dl     = time_q + {16'd0, req_q.timeout_ticks};
  assign new_rel    = {16'd0, req_q.timeout_ticks};
  assign rel_rd     = rdata.deadline - time_q;
  assign rd_reached = (rel_rd == 32'd0) || rel_rd[31];
  // new goes before rd when key(new) < key(rd); keys are rel + 2^31
  assign new_before = ({~new_rel[31], new_rel[30:0]} < {~rel_rd[31], rel_rd[30:0]});
  assign new_ent    = {req_q.request_tag, req_q.block_type, new_dl};
  assign head       = fwd_q ? new_ent : rdata;
  assign head_rel   = head.deadline - time_q;

  assign out_free = !out_v_q || res_ready_i;
  assign emit_ok  = !pend_v_q || out_free;

  assign req_ready_o = (state_q == StIdle);
  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  function automatic res_t mk(event_e ev, logic [15:0] tag);
    res_t r;
    r = '0;
    r.event_res = ev;
    r.tag_out = tag;
    return r;
  endfunction

  // Sequence each request through the entry memory.
  always_comb begin
    logic push;
    res_t ev;
    state_d = state_q; count_d = count_q; run_valid_d = run_valid_q;
    run_tag_d = run_tag_q; run_canc_d = run_canc_q; time_d = time_q;
    ri_d = ri_q; wi_d = wi_q; found_d = found_q; fwd_d = fwd_q;
    out_d = out_q; out_v_d = out_v_q && !res_ready_i;
    pend_d = pend_q; pend_v_d = pend_v_q;
    we = 1'b0; waddr = ri_q[AW-1:0]; wdata = rdata;
    push = 1'b0; ev = '0;
    unique case (state_q)
      StIdle: begin
        found_d = 1'b0; fwd_d = 1'b0; wi_d = '0;
        if (req_valid_i) begin
          unique case (req_i.action)
            ActSubmit: begin
              if (count_q >= DepthC) begin
                push = 1'b1; ev = mk(EvReject, req_i.request_tag);
                state_d = StDone;
              end else if (count_q == '0) begin
                ri_d = '0; state_d = StIns;
              end else begin
                ri_d = count_q - CW'(1); state_d = StScan;
              end
            end
            ActCancel: begin
              if (run_valid_q && run_tag_q == req_i.request_tag) begin
                run_canc_d = 1'b1; state_d = StDone;
              end else if (count_q == '0) state_d = StDone;
              else begin ri_d = '0; state_d = StScan; end
            end
            ActTick: begin
              time_d = time_q + 32'd1;
              if (count_q == '0) state_d = StDone;
              else begin ri_d = '0; state_d = StScan; end
            end
            ActResult: begin
              if (!run_valid_q) state_d = StDone;
              else if (!req_i.end_of_results) begin
                push = 1'b1; ev = mk(run_canc_q ? EvAbort : EvDeliver, run_tag_q);
                state_d = StDone;
              end else begin
                if (!run_canc_q) begin
                  push = 1'b1; ev = mk(EvFinished, run_tag_q);
                end
                run_valid_d = 1'b0; run_tag_d = '0; run_canc_d = 1'b0;
                state_d = StDisp;
              end
            end
            ActShutdown: begin
              if (count_q == '0) state_d = StFlRun;
              else begin ri_d = '0; state_d = StScan; end
            end
            default: state_d = StDone;
          endcase
        end
      end
      StScan: begin
        unique case (req_q.action)
          ActSubmit: begin
            // walk down from the tail, shifting entries that sort after new
            if (req_q.at_head || new_before) begin
              we = 1'b1; waddr = AW'(ri_q + CW'(1)); wdata = rdata;
              if (ri_q == '0) state_d = StIns;
              else ri_d = ri_q - CW'(1);
            end else begin
              ri_d = ri_q + CW'(1); state_d = StIns;
            end
          end
          ActCancel: begin
            // drop the first match, close the gap behind it
            if (found_q) begin
              we = 1'b1; waddr = wi_q[AW-1:0]; wi_d = wi_q + CW'(1);
            end else if (rdata.tag == req_q.request_tag) begin
              found_d = 1'b1;
            end else begin
              wi_d = wi_q + CW'(1);
            end
            if (ri_q + CW'(1) >= count_q) begin
              if (found_d) count_d = count_q - CW'(1);
              state_d = StDone;
            end else ri_d = ri_q + CW'(1);
          end
          ActTick: begin
            // expire reached entries, compact the rest; hold while an event waits
            if (!rd_reached || emit_ok) begin
              if (rd_reached) begin
                push = 1'b1; ev = mk(EvExpired, rdata.tag);
              end else begin
                we = 1'b1; waddr = wi_q[AW-1:0]; wi_d = wi_q + CW'(1);
              end
              if (ri_q + CW'(1) >= count_q) begin
                count_d = wi_d; state_d = StDone;
              end else ri_d = ri_q + CW'(1);
            end
          end
          ActShutdown: begin
            if (emit_ok) begin
              push = 1'b1; ev = mk(EvFlushed, rdata.tag);
              if (ri_q + CW'(1) >= count_q) begin
                count_d = '0; state_d = StFlRun;
              end else ri_d = ri_q + CW'(1);
            end
          end
          default: state_d = StDone;
        endcase
      end
      StIns: begin
        we = 1'b1; waddr = ri_q[AW-1:0]; wdata = new_ent;
        count_d = count_q + CW'(1);
        fwd_d = (ri_q == '0);
        state_d = run_valid_q ? StDone : StDisp;
      end
      StDisp: begin
        if (count_q == '0) state_d = StDone;
        else if (emit_ok) begin
          push = 1'b1;
          ev = mk(EvDispatch, head.tag);
          ev.type_out = head.btype;
          ev.remaining_ticks = head_rel[31] ? 16'd0 :
                               (head_rel[31:16] != 16'd0) ? 16'hFFFF : head_rel[15:0];
          run_valid_d = 1'b1; run_tag_d = head.tag; run_canc_d = 1'b0;
          fwd_d = 1'b0;
          if (count_q == CW'(1)) begin
            count_d = '0; state_d = StDone;
          end else begin
            ri_d = CW'(1); state_d = StShift;
          end
        end
      end
      StShift: begin
        // remove the dispatched head: move each entry down by one
        we = 1'b1; waddr = AW'(ri_q - CW'(1)); wdata = rdata;
        if (ri_q + CW'(1) >= count_q) begin
          count_d = count_q - CW'(1); state_d = StDone;
        end else ri_d = ri_q + CW'(1);
      end
      StFlRun: begin
        if (run_valid_q && !run_canc_q) begin
          if (emit_ok) begin
            push = 1'b1; ev = mk(EvFlushed, run_tag_q);
            run_valid_d = 1'b0; run_tag_d = '0; run_canc_d = 1'b0;
            state_d = StDone;
          end
        end else begin
          run_valid_d = 1'b0; run_tag_d = '0; run_canc_d = 1'b0;
          state_d = StDone;
        end
      end
      StDone: begin
        // release the held event as the final one of this request
        if (!pend_v_q) state_d = StIdle;
        else if (out_free) begin
          out_d = pend_q; out_d.last = 1'b1; out_v_d = 1'b1;
          pend_v_d = 1'b0; state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    // advance the held event to the output when a newer one arrives
    if (push) begin
      if (pend_v_q) begin
        out_d = pend_q; out_d.last = 1'b0; out_v_d = 1'b1;
      end
      pend_d = ev; pend_v_d = 1'b1;
    end
    if (state_d == StDisp) raddr = '0;
    else raddr = ri_d[AW-1:0];
  end

  // Hold control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; count_q <= '0; run_valid_q <= 1'b0; run_tag_q <= '0;
      run_canc_q <= 1'b0; time_q <= '0; out_v_q <= 1'b0; pend_v_q <= 1'b0;
      ri_q <= '0; wi_q <= '0; found_q <= 1'b0; fwd_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; run_valid_q <= run_valid_d;
      run_tag_q <= run_tag_d; run_canc_q <= run_canc_d; time_q <= time_d;
      out_v_q <= out_v_d; pend_v_q <= pend_v_d; ri_q <= ri_d; wi_q <= wi_d;
      found_q <= found_d; fwd_q <= fwd_d;
    end
  end

  // Hold payload.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    pend_q <= pend_d;
    if (state_q == StIdle && req_valid_i) req_q <= req_i;
  end

endmodule
`default_nettype wire

FILE: rtl/dorq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dorq_checker
  import dorq_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_valid_i,
  input wire logic req_ready_o,
  input wire req_t req_i,
  input wire logic res_valid_o,
  input wire logic res_ready_i,
  input wire res_t res_o
);

  // A stalled result keeps its valid.
  `ASSERT_CLK(a_res_hold, res_valid_o && !res_ready_i |=> res_valid_o, "result dropped")
  // Event codes stay within the defined set.
  `ASSERT_NEVER(a_ev_code, res_valid_o && res_o.event_res > EvFinished, "bad event code")
  // Only a dispatch carries a type.
  `ASSERT_NEVER(a_type, res_valid_o && res_o.event_res != EvDispatch && res_o.type_out != '0,
    "type on non-dispatch")
  // A request is not taken the cycle after another was taken.
  `ASSERT_CLK(a_one_at_time, req_valid_i && req_ready_o |=> !req_ready_o, "overlap")

endmodule

bind deadline_ordered_request_queue_core dorq_checker u_dorq_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid_i(req_valid_i), .req_ready_o(req_ready_o),
  .req_i(req_i), .res_valid_o(res_valid_o), .res_ready_i(res_ready_i), .res_o(res_o)
);
`default_nettype wire
